@@ rtl/core/bra_pkg.sv @@
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types and constants for the bitmap run allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

  // Default geometry of the scratch space
  localparam int unsigned NUM_CELLS_DEF  = 4096;
  localparam int unsigned CELL_BYTES_DEF = 16;

  // Field widths
  localparam int unsigned OFS_W = 16;  // byte offset fields
  localparam int unsigned LEN_W = 12;  // byte length field and cell count
  localparam int unsigned EXT_W = 17;  // cell index plus run length headroom

  // Request codes carried on the input tuser
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_INIT,     // clear the bitmap after reset
    ST_IDLE,     // wait for a request
    ST_DIV,      // round length to cells, offset to start cell
    ST_SETUP,    // decide what to scan or sweep
    ST_SCAN,     // first-fit search, one map word per cycle
    ST_ALLOC,    // derive the start cell of the found run
    ST_RANGE,    // load word range of the run
    ST_SWEEP     // read-modify-write the run, one map word per cycle
  } bra_state_e;

  // Done is folded into a separate flag so the enum stays tight
endpackage : bra_pkg

@@ rtl/core/bitmap_run_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_run_allocator
// First-fit run allocator over an occupancy bitmap held in one memory.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser selects allocate or free,
// tdata carries the byte offset (free only) and the byte length. Each request
// produces exactly one transaction on the m_axis channel: tdata is the granted
// byte offset (0 on free, failure or zero length), tuser is the no-space flag.
// The bitmap lives in a MAP_WORDS x 8 memory with a registered read port.
// After reset the block sweeps zeros through all MAP_WORDS words with
// s_axis_tready low.
// One request is handled at a time. An allocate reads one map word per cycle
// until the first fitting run ends, then rewrites the words the run covers;
// a failed allocate reads every map word and rewrites none. A free only
// rewrites its words, and a zero length request touches no map word.
// The memory port, one word per cycle, sets the pace of both.
// The next request can be taken as soon as the previous result has entered
// the output register. If the receiver stalls, the next result waits at the
// end of its work until the output register has been taken.
// ----------------------------------------------------------------------------
module bitmap_run_allocator
  import bra_pkg::*;
#(
  parameter int unsigned NUM_CELLS  = NUM_CELLS_DEF,
  parameter int unsigned CELL_BYTES = CELL_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] offset_bytes, [27:16] length_bytes
  input  logic        s_axis_tuser_i,   // [0] func
  // result channel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] granted_offset
  output logic        m_axis_tuser_o    // [0] no_space
);

  // Map geometry
  localparam int unsigned MAP_WORDS = (NUM_CELLS + 7) / 8;
  localparam int unsigned WW        = $clog2(MAP_WORDS);
  localparam int          TAIL_BITS = (NUM_CELLS % 8 == 0) ? 8 : int'(NUM_CELLS % 8);
  localparam logic [WW-1:0]    LAST_WORD = WW'(MAP_WORDS - 1);
  localparam logic [EXT_W-1:0] CELLS_EXT = EXT_W'(NUM_CELLS);
  localparam logic [EXT_W-1:0] LAST_CELL = EXT_W'(NUM_CELLS - 1);

  // Reciprocals for division by CELL_BYTES
  localparam int unsigned LEN_SHIFT = 21;
  localparam int unsigned OFS_SHIFT = 24;
  localparam logic [21:0] LEN_RECIP = 22'(((1 << LEN_SHIFT) + CELL_BYTES - 1) / CELL_BYTES);
  localparam logic [24:0] OFS_RECIP = 25'(((1 << OFS_SHIFT) + CELL_BYTES - 1) / CELL_BYTES);
  localparam logic [8:0]  CB_VAL    = 9'(CELL_BYTES);
  localparam logic [12:0] CB_ROUND  = 13'(CELL_BYTES - 1);

  // Control state
  bra_state_e    state_q, state_d;
  logic          done_q, done_d;
  logic          rd_v_q, rd_v_d;
  logic          issue_q, issue_d;
  logic          out_valid_q, out_valid_d;
  logic [WW-1:0] rp_q, rp_d;

  // Payload state
  logic             func_q, func_d;
  logic [OFS_W-1:0] ofs_q, ofs_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] cells_q, cells_d;
  logic [EXT_W-1:0] start_q, start_d;
  logic [EXT_W-1:0] hi_q, hi_d;
  logic [LEN_W-1:0] run_q, run_d;
  logic [WW-1:0]    first_w_q, first_w_d;
  logic [WW-1:0]    last_w_q, last_w_d;
  logic [WW-1:0]    rd_a_q, rd_a_d;
  logic [OFS_W-1:0] gr_q, gr_d;
  logic             fail_q, fail_d;
  logic [OFS_W-1:0] out_ofs_q, out_ofs_d;
  logic             out_ns_q, out_ns_d;

  // Memory port
  logic [7:0]    map_mem [MAP_WORDS];
  logic [7:0]    rd_data_q;
  logic          mem_we;
  logic [WW-1:0] mem_wa;
  logic [7:0]    mem_wd;

  // Arithmetic
  logic [12:0]      len_num;
  logic [34:0]      len_prod;
  logic [40:0]      ofs_prod;
  logic [EXT_W+8:0] gr_prod;
  logic [EXT_W-1:0] run_end;

  // Scan and sweep per-word results
  logic [LEN_W-1:0] scan_run;
  logic             scan_hit;
  logic [2:0]       scan_bit;
  logic [7:0]       sweep_mask;

  assign len_num  = 13'(len_q) + CB_ROUND;
  assign len_prod = len_num * LEN_RECIP;
  assign ofs_prod = ofs_q * OFS_RECIP;
  assign gr_prod  = start_q * CB_VAL;
  assign run_end  = start_q + EXT_W'(cells_q) - EXT_W'(1);

  // Map memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= map_mem[rp_q];
  end

  // Walk the eight cells of the returned word for the first-fit run
  always_comb begin
    scan_run = run_q;
    scan_hit = 1'b0;
    scan_bit = 3'd0;
    for (int b = 0; b < 8; b++) begin
      if (!scan_hit) begin
        if (rd_data_q[b] || ((rd_a_q == LAST_WORD) && (b >= TAIL_BITS))) begin
          scan_run = '0;
        end else begin
          scan_run = scan_run + LEN_W'(1);
          if (scan_run == cells_q) begin
            scan_hit = 1'b1;
            scan_bit = 3'(b);
          end
        end
      end
    end
  end

  // Mark the cells of the returned word that lie inside the run
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      sweep_mask[b] = ((rd_a_q != first_w_q) || (3'(b) >= start_q[2:0])) &&
                      ((rd_a_q != last_w_q)  || (3'(b) <= hi_q[2:0]));
    end
  end

  // Sequencer: next state, memory access and result capture
  always_comb begin
    state_d     = state_q;
    done_d      = done_q;
    rd_v_d      = 1'b0;
    issue_d     = issue_q;
    out_valid_d = out_valid_q;
    rp_d        = rp_q;
    func_d      = func_q;
    ofs_d       = ofs_q;
    len_d       = len_q;
    cells_d     = cells_q;
    start_d     = start_q;
    hi_d        = hi_q;
    run_d       = run_q;
    first_w_d   = first_w_q;
    last_w_d    = last_w_q;
    rd_a_d      = rp_q;
    gr_d        = gr_q;
    fail_d      = fail_q;
    out_ofs_d   = out_ofs_q;
    out_ns_d    = out_ns_q;
    mem_we      = 1'b0;
    mem_wa      = rd_a_q;
    mem_wd      = rd_data_q;

    // drop the result once taken
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_INIT: begin
        // zero one map word per cycle
        mem_we = 1'b1;
        mem_wa = rp_q;
        mem_wd = '0;
        if (rp_q == LAST_WORD) begin
          rp_d    = '0;
          state_d = ST_IDLE;
        end else begin
          rp_d = rp_q + WW'(1);
        end
      end

      ST_IDLE: begin
        if (done_q) begin
          // hand over the result when the output register is free
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_d = 1'b1;
            out_ofs_d   = gr_q;
            out_ns_d    = fail_q;
            done_d      = 1'b0;
          end
        end else if (s_axis_tvalid_i) begin
          func_d  = s_axis_tuser_i;
          ofs_d   = s_axis_tdata_i[15:0];
          len_d   = s_axis_tdata_i[27:16];
          gr_d    = '0;
          fail_d  = 1'b0;
          state_d = ST_DIV;
        end
      end

      ST_DIV: begin
        cells_d = len_prod[LEN_SHIFT+LEN_W-1:LEN_SHIFT];
        start_d = EXT_W'(ofs_prod[OFS_SHIFT+OFS_W-1:OFS_SHIFT]);
        state_d = ST_SETUP;
      end

      ST_SETUP: begin
        if (cells_q == '0) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (func_q == FUNC_ALLOC) begin
          rp_d     = '0;
          last_w_d = LAST_WORD;
          run_d    = '0;
          issue_d  = 1'b1;
          state_d  = ST_SCAN;
        end else if (start_q >= CELLS_EXT) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          // clip the run to the end of the space
          hi_d    = (run_end > LAST_CELL) ? LAST_CELL : run_end;
          state_d = ST_RANGE;
        end
      end

      ST_SCAN: begin
        // issue the next read ahead of the returned word
        if (issue_q) begin
          if (rp_q == last_w_q) begin
            issue_d = 1'b0;
          end else begin
            rp_d = rp_q + WW'(1);
          end
          rd_v_d = 1'b1;
        end
        if (rd_v_q) begin
          run_d = scan_run;
          if (scan_hit) begin
            hi_d    = EXT_W'({rd_a_q, scan_bit});
            issue_d = 1'b0;
            rd_v_d  = 1'b0;
            state_d = ST_ALLOC;
          end else if (rd_a_q == LAST_WORD) begin
            fail_d  = 1'b1;
            issue_d = 1'b0;
            rd_v_d  = 1'b0;
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end

      ST_ALLOC: begin
        start_d = hi_q + EXT_W'(1) - EXT_W'(cells_q);
        state_d = ST_RANGE;
      end

      ST_RANGE: begin
        first_w_d = start_q[WW+2:3];
        last_w_d  = hi_q[WW+2:3];
        rp_d      = start_q[WW+2:3];
        issue_d   = 1'b1;
        state_d   = ST_SWEEP;
      end

      ST_SWEEP: begin
        if (func_q == FUNC_ALLOC) begin
          gr_d = gr_prod[OFS_W-1:0];
        end
        if (issue_q) begin
          if (rp_q == last_w_q) begin
            issue_d = 1'b0;
          end else begin
            rp_d = rp_q + WW'(1);
          end
          rd_v_d = 1'b1;
        end
        // write back the modified word
        if (rd_v_q) begin
          mem_we = 1'b1;
          mem_wa = rd_a_q;
          mem_wd = (func_q == FUNC_ALLOC) ? (rd_data_q | sweep_mask)
                                          : (rd_data_q & ~sweep_mask);
          if (rd_a_q == last_w_q) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      done_q      <= 1'b0;
      rd_v_q      <= 1'b0;
      issue_q     <= 1'b0;
      out_valid_q <= 1'b0;
      rp_q        <= '0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      rd_v_q      <= rd_v_d;
      issue_q     <= issue_d;
      out_valid_q <= out_valid_d;
      rp_q        <= rp_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    ofs_q     <= ofs_d;
    len_q     <= len_d;
    cells_q   <= cells_d;
    start_q   <= start_d;
    hi_q      <= hi_d;
    run_q     <= run_d;
    first_w_q <= first_w_d;
    last_w_q  <= last_w_d;
    rd_a_q    <= rd_a_d;
    gr_q      <= gr_d;
    fail_q    <= fail_d;
    out_ofs_q <= out_ofs_d;
    out_ns_q  <= out_ns_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE) && !done_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_ofs_q;
  assign m_axis_tuser_o  = out_ns_q;

endmodule : bitmap_run_allocator
